// File: design/s2h_pkg.sv
package s2h_pkg;

    localparam int SingleWidth = 32;
    localparam int HalfWidth   = 16;

    localparam logic [14:0] HalfExpMask = 15'h7C00;
    localparam logic [9:0]  QuietBit    = 10'h200;

    typedef logic [SingleWidth-1:0] single_t;
    typedef logic [HalfWidth-1:0]   half_t;

    // round to nearest even on a 24-bit significand shifted right by s (14..24)
    function automatic logic [14:0] round_sig(input logic [23:0] m, input logic [4:0] s);
        logic [47:0] ext;
        logic [23:0] q;
        logic [23:0] rem;
        logic        half_bit;
        logic        sticky;
        begin
            ext      = {m, 24'd0} >> s;
            q        = ext[47:24];
            rem      = ext[23:0];
            half_bit = rem[23];
            sticky   = |rem[22:0];
            round_sig = q[14:0] + {14'd0, half_bit & (sticky | q[0])};
        end
    endfunction

    function automatic half_t narrow(input single_t x);
        logic        sgn;
        logic [7:0]  ex;
        logic [22:0] man;
        logic [9:0]  payload;
        logic [14:0] mag;
        begin
            sgn     = x[31];
            ex      = x[30:23];
            man     = x[22:0];
            payload = man[22:13];
            if (ex == 8'hFF)
            begin
                if (man == 23'd0)
                    mag = HalfExpMask;
                else if (payload == 10'd0)
                    mag = HalfExpMask | {5'd0, QuietBit};
                else
                    mag = HalfExpMask | {5'd0, payload};
            end
            else if (ex == 8'd0)
                mag = 15'd0;
            else if (ex >= 8'd143)
                mag = HalfExpMask;
            else if (ex >= 8'd113)
            begin
                // carry from rounding runs into the exponent field
                mag = {ex[4:0] - 5'd16, man[22:13]}
                      + {14'd0, man[12] & ((|man[11:0]) | man[13])};
            end
            else if (ex < 8'd102)
                mag = 15'd0;
            else
                mag = round_sig({1'b1, man}, 5'(8'd126 - ex));
            narrow = {sgn, mag};
        end
    endfunction

endpackage

// File: design/single_to_half_float_narrow.sv
// channel  dir  tdata                    tlast
// s_axis   in   [31:0] single_bits       last_in
// m_axis   out  [15:0] half_bits         last_out
// one item per cycle while m_axis accepts; input register, then result register
// reset clears both valid flags; data registers are not reset
// a stall on m_axis holds the result and fills the input stage, then
// s_axis_tready drops; no transfer is lost
module single_to_half_float_narrow
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  s2h_pkg::single_t     s_axis_tdata,   // [31:0] single_bits
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output s2h_pkg::half_t       m_axis_tdata,   // [15:0] half_bits
    output logic                 m_axis_tlast
);
    import s2h_pkg::*;

    logic    in_valid_reg;
    single_t in_data_reg;
    logic    in_last_reg;
    logic    out_valid_reg;
    half_t   out_data_reg;
    logic    out_last_reg;
    logic    out_load;
    logic    in_load;

    assign out_load      = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || out_load;
    assign in_load       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (!out_valid_reg || m_axis_tready)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_data_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (out_load)
        begin
            out_data_reg <= narrow(in_data_reg);
            out_last_reg <= in_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// File: design/s2h_checker.sv
module s2h_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [31:0] s_axis_tdata,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    // held result stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // ready output always when the result register is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

    // an accepted item passes the input register into the result register when nothing stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && m_axis_tready ##1 m_axis_tready
        |=> m_axis_tvalid)
        else $error("result missing");

    // infinity in gives infinity out
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tdata[30:0] == 31'h7F800000
        ##1 m_axis_tready ##1 m_axis_tready |-> m_axis_tdata[14:0] == 15'h7C00)
        else $error("infinity not preserved");
endmodule

bind single_to_half_float_narrow s2h_checker u_s2h_checker
(
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);

// File: dv/single_to_half_float_narrow_tb.sv
`timescale 1ns / 1ps

module single_to_half_float_narrow_tb;

    import s2h_pkg::*;

    typedef struct packed {
        logic [15:0] half_bits;
        logic        last;
    } half_item_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    single_t     s_axis_tdata;   // [31:0] single_bits
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    half_t       m_axis_tdata;   // [15:0] half_bits
    logic        m_axis_tlast;

    half_item_t  expected_halves[$];
    int          mismatch_count;
    int          result_count;
    int          idle_cycles;
    bit          hold_off;
    int          sent_count;

    single_to_half_float_narrow u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // round to nearest even of m >> s
    function automatic logic [31:0] shift_rne(input logic [31:0] m, input int s);
        logic [31:0] q;
        logic [31:0] rem;
        logic [31:0] half;
        begin
            q    = m >> s;
            rem  = m & ((32'd1 << s) - 32'd1);
            half = 32'd1 << (s - 1);
            if (rem > half || (rem == half && q[0]))
                q = q + 32'd1;
            shift_rne = q;
        end
    endfunction

    function automatic logic [15:0] to_half(input logic [31:0] x);
        logic [15:0] sgn;
        logic [31:0] ex;
        logic [31:0] man;
        logic [31:0] payload;
        logic [31:0] base;
        begin
            sgn = {x[31], 15'd0};
            ex  = {24'd0, x[30:23]};
            man = {9'd0, x[22:0]};
            if (ex == 32'd255)
            begin
                if (man == 32'd0)
                    to_half = sgn | 16'h7C00;
                else
                begin
                    payload = (man >> 13) & 32'h3FF;
                    if (payload == 32'd0)
                        payload = 32'h200;
                    to_half = sgn | 16'h7C00 | payload[15:0];
                end
            end
            else if (ex == 32'd0)
                to_half = sgn;
            else if (ex >= 32'd143)
                to_half = sgn | 16'h7C00;
            else if (ex >= 32'd113)
            begin
                base = ((ex - 32'd112) << 10) | (man >> 13);
                base = shift_rne((base << 13) | (man & 32'h1FFF), 13);
                to_half = sgn | base[15:0];
            end
            else if (126 - ex >= 25)
                to_half = sgn;
            else
            begin
                base = shift_rne(man | 32'h800000, 126 - ex);
                to_half = sgn | base[15:0];
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        begin
            $display("mismatch on %s at result %0d: got %h expected %h",
                     what, result_count, got, want);
            mismatch_count++;
        end
    endtask

    // valid stays high after a transfer until the next call drops it or offers new data
    task automatic send_single(input logic [31:0] bits, input logic last);
        int gap;
        begin
            gap = $urandom_range(0, 14);
            if ($urandom_range(0, 3) == 0)
                gap = 0;
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap)
                    @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= bits;
            s_axis_tlast  <= last;
            @(posedge clk);
            while (!s_axis_tready)
                @(posedge clk);
            expected_halves.push_back('{to_half(bits), last});
            sent_count++;
        end
    endtask

    // receiver stall per result, or a long hold-off on request
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                m_axis_tready <= 1'b0;
                repeat (200)
                    @(posedge clk);
                hold_off = 1'b0;
            end
            else
            begin
                stall = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14));
                if (stall != 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (stall)
                        @(posedge clk);
                end
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!(m_axis_tvalid && m_axis_tready))
                @(posedge clk);
        end
    end

    // result check
    always @(posedge clk)
    begin
        half_item_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_halves.size() == 0)
                report_mismatch("unexpected transfer", m_axis_tdata, 16'd0);
            else
            begin
                want = expected_halves.pop_front();
                if (m_axis_tdata !== want.half_bits)
                    report_mismatch("half_bits", m_axis_tdata, want.half_bits);
                if (m_axis_tlast !== want.last)
                    report_mismatch("last", {15'd0, m_axis_tlast}, {15'd0, want.last});
            end
            result_count++;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic test_directed();
        logic [31:0] patterns [0:23];
        begin
            patterns = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h807F_FFFF,
                         32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'hFF80_0001,
                         32'h7F80_2000, 32'h7FFF_FFFF, 32'h3F80_0000, 32'h477F_E000,
                         32'h477F_F000, 32'h477F_EFFF, 32'h4780_0000, 32'h7F7F_FFFF,
                         32'h3880_0000, 32'h387F_C000, 32'h387F_E000, 32'h3380_0000,
                         32'h3300_0000, 32'h3300_0001, 32'h3F80_3000, 32'h3F80_1000};
            foreach (patterns[i])
                send_single(patterns[i], i[0]);
        end
    endtask

    task automatic test_random();
        logic [31:0] bits;
        int kind;
        begin
            repeat (500)
            begin
                bits = $urandom;
                kind = $urandom_range(0, 5);
                // steer the exponent toward the interesting bands, or the low mantissa bits toward rounding ties
                if (kind == 0)
                    bits[30:23] = 8'(($urandom_range(102, 143)));
                else if (kind == 1)
                    bits[30:23] = 8'(($urandom_range(111, 114)));
                else if (kind == 2)
                begin
                    bits[30:23] = 8'hFF;
                    if ($urandom_range(0, 1))
                        bits[22:13] = 10'd0;
                end
                else if (kind == 3)
                    bits[12:0] = ($urandom_range(0, 1)) ? 13'h1000 : 13'h0FFF;
                send_single(bits, 1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic test_backpressure();
        begin
            hold_off = 1'b1;
            repeat (30)
                send_single($urandom, 1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        int drain;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        hold_off      = 1'b0;
        mismatch_count = 0;
        result_count   = 0;
        sent_count     = 0;
        idle_cycles    = 0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random();
        s_axis_tvalid <= 1'b0;
        drain = 0;
        while (expected_halves.size() != 0 && drain < 5000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (10)
            @(posedge clk);
        $display("converted %0d single values, checked %0d half results", sent_count,
                 result_count);
        $display("covered zeros, subnormals, rounding carries, overflow, inf and nan");
        if (mismatch_count == 0 && expected_halves.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: sim.f
design/s2h_pkg.sv
design/single_to_half_float_narrow.sv
design/s2h_checker.sv
dv/single_to_half_float_narrow_tb.sv
